### rtl/core/rdq_pkg.sv
// Shared types and constants for the reversible deque.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none
package rdq_pkg;

    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int OCC_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        CMD_POP_BACK   = 3'd0,
        CMD_POP_FRONT  = 3'd1,
        CMD_REVERSE    = 3'd2,
        CMD_PUSH_BACK  = 3'd3,
        CMD_PUSH_FRONT = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Controller to datapath
    typedef struct packed {
        logic    latch;     // capture the incoming beat
        logic    push;      // write the held value at the selected end
        logic    pop;       // read and remove at the selected end
        logic    rev;       // toggle the reverse flag
        logic    load_out;  // load the result register
        t_status status;    // status to load
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic             is_pop;
        logic             is_push;
        logic             is_rev;
        logic             empty;
        logic             full;
        logic             out_busy;
        logic             ptr_eq;
        logic [OCC_W-1:0] occ;
    } t_dp_stat;

endpackage
`default_nettype wire

### rtl/core/rdq_ctrl.sv
// Sequencing state machine for the reversible deque.
// Depends on rdq_pkg; drives the command struct of rdq_dpath.
`default_nettype none
module rdq_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  rdq_pkg::t_dp_stat i_stat,
    output rdq_pkg::t_dp_cmd  o_cmd
);
    import rdq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state  r_state, n_state;
    t_status r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_cmd    = '0;
        o_cmd.status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                priority if (i_stat.is_pop) begin
                    n_state = S_OUT;
                    if (i_stat.empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_status  = ST_OK;
                        o_cmd.pop = 1'b1;
                    end
                end else if (i_stat.is_push) begin
                    if (i_stat.full) begin
                        n_status = ST_FULL;
                        n_state  = S_OUT;
                    end else begin
                        o_cmd.push = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else if (i_stat.is_rev) begin
                    o_cmd.rev = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    // unused codes: drop silently
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                // hold until the result register is free
                if (!i_stat.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/core/rdq_dpath.sv
// Ring buffer, pointers, reverse flag and result register of the deque.
// Depends on rdq_pkg; steered by rdq_ctrl through the command struct.
`default_nettype none
module rdq_dpath (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire  [2:0]                i_command,
    input  wire  [rdq_pkg::DATA_W-1:0] i_value,
    input  rdq_pkg::t_dp_cmd          i_cmd,
    output rdq_pkg::t_dp_stat         o_stat,
    output logic                      o_out_valid,
    input  wire                       i_out_ready,
    output logic [1:0]                o_status,
    output logic [rdq_pkg::DATA_W-1:0] o_popped_value
);
    import rdq_pkg::*;

    logic [2:0]        r_cmd;
    logic [DATA_W-1:0] r_val;
    logic [ADDR_W-1:0] r_head, n_head;
    logic [ADDR_W-1:0] r_tail, n_tail;
    logic [OCC_W-1:0]  r_occ, n_occ;
    logic              r_rev;
    logic [DATA_W-1:0] r_rdata;
    logic              r_ovalid;
    t_status           r_ostatus;
    logic [DATA_W-1:0] r_oval;

    logic [DATA_W-1:0] mem [DEPTH];

    logic              at_back;
    logic [ADDR_W-1:0] head_next, head_prev, tail_next, tail_prev;
    logic [ADDR_W-1:0] rd_addr, wr_addr;

    function automatic logic [ADDR_W-1:0] ptr_next(input logic [ADDR_W-1:0] p);
        return (p == ADDR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] ptr_prev(input logic [ADDR_W-1:0] p);
        return (p == '0) ? ADDR_W'(DEPTH - 1) : p - 1'b1;
    endfunction

    assign head_next = ptr_next(r_head);
    assign head_prev = ptr_prev(r_head);
    assign tail_next = ptr_next(r_tail);
    assign tail_prev = ptr_prev(r_tail);

    // logical back is the physical back unless the flag is set
    assign at_back = ((r_cmd == CMD_POP_BACK) || (r_cmd == CMD_PUSH_BACK)) != r_rev;

    assign rd_addr = at_back ? tail_prev : r_head;
    assign wr_addr = at_back ? r_tail : head_prev;

    always_comb begin
        o_stat          = '0;
        o_stat.is_pop   = (r_cmd == CMD_POP_BACK) || (r_cmd == CMD_POP_FRONT);
        o_stat.is_push  = (r_cmd == CMD_PUSH_BACK) || (r_cmd == CMD_PUSH_FRONT);
        o_stat.is_rev   = (r_cmd == CMD_REVERSE);
        o_stat.empty    = (r_occ == '0);
        o_stat.full     = (r_occ == OCC_W'(DEPTH));
        o_stat.out_busy = r_ovalid && !i_out_ready;
        o_stat.ptr_eq   = (r_head == r_tail);
        o_stat.occ      = r_occ;
    end

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_occ  = r_occ;
        if (i_cmd.push) begin
            n_occ = r_occ + 1'b1;
            if (at_back) begin
                n_tail = tail_next;
            end else begin
                n_head = head_prev;
            end
        end else if (i_cmd.pop) begin
            n_occ = r_occ - 1'b1;
            if (at_back) begin
                n_tail = tail_prev;
            end else begin
                n_head = head_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_occ    <= '0;
            r_rev    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_occ  <= n_occ;
            if (i_cmd.rev) begin
                r_rev <= !r_rev;
            end
            if (i_cmd.load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd <= i_command;
            r_val <= i_value;
        end
        if (i_cmd.load_out) begin
            r_ostatus <= i_cmd.status;
            r_oval    <= (i_cmd.status == ST_OK) ? r_rdata : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[wr_addr] <= r_val;
        end
        if (i_cmd.pop) begin
            r_rdata <= mem[rd_addr];
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_status       = r_ostatus;
    assign o_popped_value = r_oval;

endmodule
`default_nettype wire

### rtl/core/reversible_deque.sv
// Reversible deque: one command per beat, at most one result beat per command.
// Sequencing: push, reverse and unused codes pass through the execute state and return to idle;
// a pop or a refused push also passes the output state, which loads the output register.
// A new command is taken only in the idle state, once the previous one is through; the output
// state holds while the output register still holds an unaccepted result.
// Reset clears pointers, occupancy, the reverse flag and the output valid flag; memory is left as is.
`default_nettype none
module reversible_deque (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [39:0] s_axis_tdata,   // [2:0] command, [34:3] value, [39:35] zero
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata    // [1:0] status, [33:2] popped_value, [39:34] zero
);
    import rdq_pkg::*;

    t_dp_cmd           dp_cmd;
    t_dp_stat          dp_stat;
    logic [1:0]        out_status;
    logic [DATA_W-1:0] out_value;

    rdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    rdq_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_command      (s_axis_tdata[2:0]),
        .i_value        (s_axis_tdata[34:3]),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_status       (out_status),
        .o_popped_value (out_value)
    );

    assign m_axis_tdata = {6'd0, out_value, out_status};

    // occupancy stays within the ring
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_stat.occ <= OCC_W'(DEPTH))
        else $error("occupancy beyond depth");

    // an empty queue has coincident pointers
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_stat.empty |-> dp_stat.ptr_eq)
        else $error("empty queue with pointers apart");

    // one command in flight: no beat accepted on the cycle after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("back-to-back accept");

    // a result is loaded only when the output register is free
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result register overrun");

endmodule
`default_nettype wire
